// File: rtl/core/tlpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_pkg
// Shared types and constants for the type/length prefixed deframer.
// ----------------------------------------------------------------------------
package tlpd_pkg;

    // Header layout: 16-bit type, 16-bit total size, both little endian
    localparam logic [15:0] HEADER_BYTES = 16'd4;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 3;
    localparam logic [2:0]  REG_TYPE_COUNT  = 3'd0;
    localparam int          REG_LIMITS_BASE = 1;
    localparam int          LIMIT_WORDS     = 4;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Framing phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DEAD    = 2'd2
    } phase_t;

    // Limits looked up for the type of the header being checked
    typedef struct packed {
        logic        type_ok;
        logic [15:0] min_size;
        logic [15:0] max_size;
    } lim_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] pkt_type;
        logic [15:0] pkt_size;
        logic        last;
    } res_t;

endpackage

// File: rtl/core/typed_length_prefix_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_length_prefix_deframer_core
// Splits a byte stream into type/length prefixed packets and passes the
// payload out tagged with type and size.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless m_axis_tready stalls the output, and gives
// at most one result per byte. A byte goes into an input register, is decoded
// against the framing state and lands in the output register, which drives
// m_axis_tvalid. The input register frees whenever the output register is
// empty or being taken, so s_axis_tready follows m_axis_tready within the same
// cycle. Only the last header byte can give a result; killed-session bytes give none.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// are meant for an idle block.
module typed_length_prefix_deframer_core
    import tlpd_pkg::*;
#(
    parameter int MAX_TYPES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic                 s_axis_tuser,   // [0] new_session
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // [7:0] out_byte, [23:8] pkt_type,
                                                 // [39:24] pkt_size
    output logic [1:0]           m_axis_tuser,   // [1:0] out_kind
    output logic                 m_axis_tlast    // last
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_new_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    logic        step;
    logic        res_valid;
    res_t        res;
    lim_t        lim;
    logic [15:0] lookup_type;

    assign cfg_ready     = 1'b1;
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    // Input register: hold the item until it is decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_new_reg  <= s_axis_tuser;
        end
    end

    tlpd_cfg #(
        .MAX_TYPES (MAX_TYPES)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .lookup_type (lookup_type),
        .lim         (lim)
    );

    tlpd_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .new_session (in_new_reg),
        .lim         (lim),
        .lookup_type (lookup_type),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register: load on decode, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.pkt_size, out_res_reg.pkt_type, out_res_reg.data};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last;

`ifndef SYNTH
    // Error results are final and carry no byte
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_ERROR)
        |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("error result without last or with data");

    // Header-only completion only for a size equal to the header
    a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_EMPTY)
        |-> m_axis_tlast && (m_axis_tdata[39:24] == HEADER_BYTES))
        else $error("header-only result with wrong size");

    // Payload bytes only for packets longer than the header
    a_data_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_DATA)
        |-> (m_axis_tdata[39:24] > HEADER_BYTES))
        else $error("payload result for a packet without payload");

    // A waiting input item is neither lost nor altered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step
        |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_new_reg))
        else $error("input item lost while waiting");
`endif

endmodule

// File: rtl/core/tlpd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_cfg
// Configuration registers (type count and per-type size limits) and the
// limit lookup for the type of the header under check.
// ----------------------------------------------------------------------------
module tlpd_cfg
    import tlpd_pkg::*;
#(
    parameter int MAX_TYPES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [15:0]          lookup_type,
    output lim_t                 lim
);

    localparam int         NUM_PAIRS = (MAX_TYPES + 1) / 2;
    localparam logic [3:0] MAX_CNT   = 4'(MAX_TYPES);

    logic [3:0]  type_count_reg;
    logic [63:0] limits_reg [NUM_PAIRS];
    logic [3:0]  count_eff;
    logic [63:0] word_sel;

    // Write registers; indexes past the stored words are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_count_reg <= 4'd0;
            for (int p = 0; p < NUM_PAIRS; p++)
            begin
                limits_reg[p] <= 64'd0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_TYPE_COUNT)
            begin
                type_count_reg <= cfg_data[3:0];
            end
            for (int p = 0; p < NUM_PAIRS; p++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_LIMITS_BASE + p))
                begin
                    limits_reg[p] <= cfg_data;
                end
            end
        end
    end

    // Clamp the type count and select the limit word of the type pair
    always_comb
    begin
        count_eff = (type_count_reg > MAX_CNT) ? MAX_CNT : type_count_reg;
        word_sel  = 64'd0;
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            if (lookup_type[2:1] == 2'(p))
            begin
                word_sel = limits_reg[p];
            end
        end
    end

    // Check the type against the count and pick the even or odd half of the word
    always_comb
    begin
        lim.type_ok  = (lookup_type < {12'd0, count_eff});
        lim.min_size = lookup_type[0] ? word_sel[47:32] : word_sel[15:0];
        lim.max_size = lookup_type[0] ? word_sel[63:48] : word_sel[31:16];
    end

endmodule

// File: rtl/core/tlpd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_parse
// Framing state machine: collects the header, checks it, counts the payload
// and forms at most one result per item.
// ----------------------------------------------------------------------------
module tlpd_parse
    import tlpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic        new_session,
    input  lim_t        lim,
    output logic [15:0] lookup_type,
    output logic        res_valid,
    output res_t        res
);

    phase_t      phase_reg,  phase_next,  phase_eff;
    logic [1:0]  hcount_reg, hcount_next, hcount_eff;
    logic [15:0] type_reg,   type_next,   type_eff;
    logic [15:0] size_reg,   size_next,   size_eff;
    logic [15:0] left_reg,   left_next,   left_eff;
    logic        hdr_ok;
    logic [15:0] size_asm;

    // Start from a clean session when the item says so
    always_comb
    begin
        if (new_session)
        begin
            phase_eff  = PH_HEADER;
            hcount_eff = 2'd0;
            type_eff   = 16'd0;
            size_eff   = 16'd0;
            left_eff   = 16'd0;
        end
        else
        begin
            phase_eff  = phase_reg;
            hcount_eff = hcount_reg;
            type_eff   = type_reg;
            size_eff   = size_reg;
            left_eff   = left_reg;
        end
    end

    // Header check on the last header byte
    assign lookup_type = type_eff;
    assign size_asm    = {rx_byte, size_eff[7:0]};
    assign hdr_ok      = lim.type_ok && (size_asm >= HEADER_BYTES)
                         && (size_asm >= lim.min_size) && (size_asm <= lim.max_size);

    // Next state
    always_comb
    begin
        phase_next  = phase_eff;
        hcount_next = hcount_eff;
        type_next   = type_eff;
        size_next   = size_eff;
        left_next   = left_eff;
        case (phase_eff)
            PH_HEADER:
            begin
                case (hcount_eff)
                    2'd0:    type_next = {type_eff[15:8], rx_byte};
                    2'd1:    type_next = {rx_byte, type_eff[7:0]};
                    2'd2:    size_next = {size_eff[15:8], rx_byte};
                    default: size_next = size_asm;
                endcase
                if (hcount_eff != 2'd3)
                begin
                    hcount_next = hcount_eff + 2'd1;
                end
                else
                begin
                    hcount_next = 2'd0;
                    if (!hdr_ok)
                    begin
                        phase_next = PH_DEAD;
                        left_next  = 16'd0;
                    end
                    else if (size_asm == HEADER_BYTES)
                    begin
                        left_next = 16'd0;
                    end
                    else
                    begin
                        left_next  = size_asm - HEADER_BYTES;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                left_next = left_eff - 16'd1;
                if (left_next == 16'd0)
                begin
                    phase_next  = PH_HEADER;
                    hcount_next = 2'd0;
                end
            end
            default:
            begin
                // dead session: drop the item
                phase_next = PH_DEAD;
            end
        endcase
    end

    // Result
    always_comb
    begin
        res_valid    = 1'b0;
        res.kind     = KIND_DATA;
        res.data     = 8'd0;
        res.pkt_type = type_next;
        res.pkt_size = size_next;
        res.last     = 1'b0;
        case (phase_eff)
            PH_HEADER:
            begin
                if (hcount_eff == 2'd3)
                begin
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    res.kind  = hdr_ok ? KIND_EMPTY : KIND_ERROR;
                    if (hdr_ok && (size_asm != HEADER_BYTES))
                    begin
                        res_valid = 1'b0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_DATA;
                res.data  = rx_byte;
                res.last  = (left_next == 16'd0);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Advance the state once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= 2'd0;
            type_reg   <= 16'd0;
            size_reg   <= 16'd0;
            left_reg   <= 16'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            type_reg   <= type_next;
            size_reg   <= size_next;
            left_reg   <= left_next;
        end
    end

endmodule
